### src/rbx_pkg.sv
// ----------------------------------------------------------------------------
// Romberg extrapolation package
// Widths, limits, the reciprocal table and the shared-unit control type.
// ----------------------------------------------------------------------------
package rbx_pkg;

   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int LEVEL_W     = 5;
   localparam int STORE_DEPTH = 16;
   localparam int MAX_LEVEL   = 15;
   localparam int LEVEL_LIMIT = (MAX_LEVEL < STORE_DEPTH - 1) ? MAX_LEVEL : STORE_DEPTH - 1;
   localparam int RECIP_W     = 32;
   localparam int PROD_W      = 2 * (VALUE_W + 1);

   typedef struct packed {
      logic               mul_en;
      logic [INDEX_W-1:0] order;
   } rbx_unit_ctl_type;

   // round(2^32 / (4^j - 1)) as an unsigned 0.32 fraction; order zero is unused.
   function automatic logic [RECIP_W-1:0] rbx_recip(input logic [INDEX_W-1:0] order);
      logic [RECIP_W-1:0] r;
      case (order)
         4'd1:    r = 32'd1431655765;
         4'd2:    r = 32'd286331153;
         4'd3:    r = 32'd68174084;
         4'd4:    r = 32'd16843009;
         4'd5:    r = 32'd4198404;
         4'd6:    r = 32'd1048832;
         4'd7:    r = 32'd262160;
         4'd8:    r = 32'd65537;
         4'd9:    r = 32'd16384;
         4'd10:   r = 32'd4096;
         4'd11:   r = 32'd1024;
         4'd12:   r = 32'd256;
         4'd13:   r = 32'd64;
         4'd14:   r = 32'd16;
         4'd15:   r = 32'd4;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### src/rbx_req_if.sv
// ----------------------------------------------------------------------------
// Romberg request channel
// Valid/ready channel that carries one trapezoid estimate per request.
// ----------------------------------------------------------------------------
interface rbx_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbx_pkg::VALUE_W-1:0]  estimate;
   logic                                restart;

   modport source (output valid, output estimate, output restart, input ready);
   modport sink   (input valid, input estimate, input restart, output ready);
endinterface

### src/rbx_rsp_if.sv
// ----------------------------------------------------------------------------
// Romberg response channel
// Valid/ready channel that carries one table entry per response.
// ----------------------------------------------------------------------------
interface rbx_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [rbx_pkg::INDEX_W-1:0]  row;
   logic        [rbx_pkg::INDEX_W-1:0]  column;
   logic signed [rbx_pkg::VALUE_W-1:0]  value;
   logic                                last;
   logic                                error;

   modport source (output valid, output row, output column, output value,
                   output last, output error, input ready);
   modport sink   (input valid, input row, input column, input value,
                   input last, input error, output ready);
endinterface

### src/rbx_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, read-first, registered read data.
// ----------------------------------------------------------------------------
module rbx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem_ff[addr];
         if (we) begin
            mem_ff[addr] <= wr_data;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rbx_extrap_unit.sv
// ----------------------------------------------------------------------------
// Romberg extrapolation unit
// Registered product (A - B) * recip, then floor, add and saturate.
// ----------------------------------------------------------------------------
module rbx_extrap_unit (
   input  logic                               clock,
   input  rbx_pkg::rbx_unit_ctl_type          ctl,
   input  logic signed [rbx_pkg::VALUE_W-1:0] a_val,
   input  logic signed [rbx_pkg::VALUE_W-1:0] b_val,
   output logic signed [rbx_pkg::VALUE_W-1:0] result
);
   import rbx_pkg::*;

   localparam int SUM_W = PROD_W - RECIP_W + 1;

   logic signed [VALUE_W:0]      diff;
   logic signed [VALUE_W:0]      recip_s;
   logic signed [PROD_W-1:0]     prod_in;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [SUM_W-1:0]      sum;
   logic                         too_high;
   logic                         too_low;

   assign diff    = {a_val[VALUE_W-1], a_val} - {b_val[VALUE_W-1], b_val};
   assign recip_s = {1'b0, rbx_recip(ctl.order)};
   assign prod_in = diff * recip_s;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // The arithmetic shift of the upper product bits is the floor of p / 2^32.
   assign sum = {{(SUM_W - VALUE_W){a_val[VALUE_W-1]}}, a_val}
              + {prod_ff[PROD_W-1], prod_ff[PROD_W-1:RECIP_W]};

   assign too_high = !sum[SUM_W-1] && (sum[SUM_W-2:VALUE_W-1] != '0);
   assign too_low  =  sum[SUM_W-1] && (sum[SUM_W-2:VALUE_W-1] != '1);

   always_comb begin
      if (too_high) begin
         result = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (too_low) begin
         result = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         result = sum[VALUE_W-1:0];
      end
   end

endmodule

### src/romberg_extrapolation_table.sv
// ----------------------------------------------------------------------------
// Romberg extrapolation table
// Keeps the last anti-diagonal of the Romberg table and emits, for each new
// trapezoid estimate, the new anti-diagonal from column 0 upward.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  req_chan  in         valid/ready    estimate (Q16.16), restart
//  rsp_chan  out        valid/ready    row, column, value (Q16.16), last, error
//
// A request at level k first shows R[k][0], then passes three steps for each
// further column (store read at the response handshake, multiply, add and
// saturate), all through one multiplier.
// A request beyond the level limit gives one error response.
// Reset is synchronous and clears the sequencer and the level count; the
// diagonal store is not cleared, since every entry is written before it is read.
// A stalled response simply holds the sequencer; no request is taken until the
// last response of the current one has gone out.
// ----------------------------------------------------------------------------
module romberg_extrapolation_table #(
   parameter int MAX_LEVEL = rbx_pkg::MAX_LEVEL
) (
   input  logic      clock,
   input  logic      reset,
   rbx_req_if.sink   req_chan,
   rbx_rsp_if.source rsp_chan
);
   import rbx_pkg::*;

   // The 16-entry store and the 4-bit row field cap the usable depth.
   localparam int LEVEL_CAP = (MAX_LEVEL < STORE_DEPTH - 1) ? MAX_LEVEL : STORE_DEPTH - 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESP,
      ST_MUL,
      ST_ADD
   } state_type;

   state_type                  state_ff,       state_in;
   logic [LEVEL_W-1:0]         level_count_ff, level_count_in;
   logic [INDEX_W-1:0]         k_ff,           k_in;
   logic [INDEX_W-1:0]         col_ff,         col_in;
   logic signed [VALUE_W-1:0]  acc_ff,         acc_in;
   logic [INDEX_W-1:0]         row_ff,         row_in;
   logic signed [VALUE_W-1:0]  value_ff,       value_in;
   logic                       last_ff,        last_in;
   logic                       err_ff,         err_in;

   logic [LEVEL_W-1:0]         k_new;
   logic [INDEX_W-1:0]         col_next;
   logic                       rsp_fire;
   logic                       ram_en;
   logic signed [VALUE_W-1:0]  old_entry;
   logic signed [VALUE_W-1:0]  unit_result;
   rbx_unit_ctl_type           unit_ctl;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign col_next = col_ff + INDEX_W'(1);

   // A restart, or the very first request after reset, opens a new table.
   assign k_new = req_chan.restart ? '0 : level_count_ff;

   // Each response handshake writes the entry just shown into its slot of the
   // store and, read-first, fetches the old entry that the next column needs.
   assign ram_en = (state_ff == ST_RESP) && rsp_chan.ready && !err_ff;

   rbx_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .en      (ram_en),
      .we      (ram_en),
      .addr    (col_ff),
      .wr_data (acc_ff),
      .rd_data (old_entry)
   );

   assign unit_ctl.mul_en = (state_ff == ST_MUL);
   assign unit_ctl.order  = col_next;

   rbx_extrap_unit u_unit (
      .clock  (clock),
      .ctl    (unit_ctl),
      .a_val  (acc_ff),
      .b_val  (old_entry),
      .result (unit_result)
   );

   always_comb begin
      state_in       = state_ff;
      level_count_in = level_count_ff;
      k_in           = k_ff;
      col_in         = col_ff;
      acc_in         = acc_ff;
      row_in         = row_ff;
      value_in       = value_ff;
      last_in        = last_ff;
      err_in         = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_RESP;
               col_in   = '0;
               if (k_new > LEVEL_W'(LEVEL_CAP)) begin
                  // Too deep: one error response, the table stays as it was.
                  err_in   = 1'b1;
                  row_in   = '0;
                  value_in = '0;
                  last_in  = 1'b1;
               end else begin
                  err_in   = 1'b0;
                  k_in     = k_new[INDEX_W-1:0];
                  acc_in   = req_chan.estimate;
                  row_in   = k_new[INDEX_W-1:0];
                  value_in = req_chan.estimate;
                  last_in  = (k_new == '0);
               end
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
                  if (!err_ff) begin
                     level_count_in = {1'b0, k_ff} + LEVEL_W'(1);
                  end
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_RESP;
            col_in   = col_next;
            acc_in   = unit_result;
            value_in = unit_result;
            row_in   = k_ff - col_next;
            last_in  = (col_next == k_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         level_count_ff <= level_count_in;
      end
      k_ff     <= k_in;
      col_ff   <= col_in;
      acc_ff   <= acc_in;
      row_ff   <= row_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = (state_ff == ST_RESP);
   assign rsp_chan.row    = row_ff;
   assign rsp_chan.column = col_ff;
   assign rsp_chan.value  = value_ff;
   assign rsp_chan.last   = last_ff;
   assign rsp_chan.error  = err_ff;

   // The block never takes a request while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   // An error response is a single, empty response.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error |->
         rsp_chan.last && (rsp_chan.value == '0) && (rsp_chan.column == '0))
      else $error("malformed error response");

   // Every regular entry lies on the anti-diagonal of the current level.
   a_diagonal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.error |->
         (rsp_chan.row + rsp_chan.column == k_ff) && (rsp_chan.column <= k_ff))
      else $error("entry off the anti-diagonal");

   // The final response of a request frees the block in the next cycle.
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_chan.last |=> req_chan.ready)
      else $error("block not released after the final response");

   // The level count never runs past one beyond the deepest level.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_count_ff <= LEVEL_W'(LEVEL_CAP + 1))
      else $error("level count out of range");

endmodule

### verif/romberg_extrapolation_table_tb.sv
// ----------------------------------------------------------------------------
// Romberg extrapolation table testbench
// Feeds trapezoid estimates into the block, predicts every table entry of
// each new anti-diagonal in fixed point, and checks each response in order.
// ----------------------------------------------------------------------------
module romberg_extrapolation_table_tb;
   import rbx_pkg::*;

   // The watchdog only counts cycles in which neither channel moves. The
   // longest such stretch in a correct run is the deliberate receiver
   // hold-off, so the limit is that stretch taken many times over.
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   // A level-15 request is the longest; the tail covers it with room.
   localparam int TAIL_CYCLES    = 60;

   localparam longint ENTRY_MAX = 64'sd2147483647;
   localparam longint ENTRY_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [VALUE_W-1:0] estimate;
      logic                      restart;
   } estimate_req_type;

   typedef struct packed {
      logic        [INDEX_W-1:0] row;
      logic        [INDEX_W-1:0] column;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      error;
   } table_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rbx_req_if req_bus ();
   rbx_rsp_if rsp_bus ();

   romberg_extrapolation_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // Requests waiting to be offered, and table entries predicted but not yet seen.
   estimate_req_type estimates_pending[$];
   table_entry_type  entries_due[$];

   // The predictor's own copy of the block state: the last anti-diagonal,
   // where entry j holds R[k-1-j][j], and the index k of the next estimate.
   logic signed [VALUE_W-1:0] diagonal_copy[STORE_DEPTH];
   logic        [LEVEL_W-1:0] next_level;

   int send_idle_pct = 10;
   int recv_idle_pct = 75;
   int mismatch_count = 0;
   int stalls_asked = 0;
   int stalls_begun = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   estimate_req_type next_req;
   table_entry_type  seen_entry;
   table_entry_type  want_entry;

   // round(2^32 / (4^order - 1)) as an unsigned 0.32 fraction. The divisor is
   // odd, so adding half of it before the division rounds without ties.
   function automatic longint recip_q32(input int order);
      longint span;
      span = (longint'(1) << (2 * order)) - 1;
      return ((longint'(1) << 32) + (span >>> 1)) / span;
   endfunction

   // One Richardson step: upper + floor((upper - lower) * recip / 2^32),
   // saturated to 32 bits. The difference and product are exact in 64 bits,
   // and an arithmetic shift of the signed product is the floor.
   function automatic logic signed [VALUE_W-1:0] refine(
      input logic signed [VALUE_W-1:0] upper,
      input logic signed [VALUE_W-1:0] lower,
      input int                        order);
      longint gap;
      longint scaled;
      longint total;
      gap    = longint'(upper) - longint'(lower);
      scaled = gap * recip_q32(order);
      total  = longint'(upper) + (scaled >>> 32);
      if (total > ENTRY_MAX) return VALUE_W'(ENTRY_MAX);
      if (total < ENTRY_MIN) return VALUE_W'(ENTRY_MIN);
      return VALUE_W'(total);
   endfunction

   // Works out the new anti-diagonal for one accepted estimate and queues its
   // entries in the order the block sends them: column 0 first, then upward.
   task automatic extend_diagonal(input logic signed [VALUE_W-1:0] estimate,
                                  input logic restart);
      logic signed [VALUE_W-1:0] fresh[STORE_DEPTH];
      table_entry_type entry;
      int level;
      if (restart) next_level = '0;
      level = int'(next_level);
      entry = '0;
      // Past the level limit the estimate is dropped with one error entry,
      // and the table stays frozen until the next restart.
      if (level > LEVEL_LIMIT) begin
         entry.last  = 1'b1;
         entry.error = 1'b1;
         entries_due.insert(entries_due.size(), entry);
         return;
      end
      fresh[0]     = estimate;
      entry.row    = INDEX_W'(level);
      entry.column = '0;
      entry.value  = estimate;
      entry.last   = (level == 0);
      entries_due.insert(entries_due.size(), entry);
      for (int j = 1; j <= level; j++) begin
         fresh[j]     = refine(fresh[j-1], diagonal_copy[j-1], j);
         entry.row    = INDEX_W'(level - j);
         entry.column = INDEX_W'(j);
         entry.value  = fresh[j];
         entry.last   = (j == level);
         entries_due.insert(entries_due.size(), entry);
      end
      for (int j = 0; j <= level; j++) diagonal_copy[j] = fresh[j];
      next_level = next_level + 1'b1;
   endtask

   task automatic offer(input logic signed [VALUE_W-1:0] estimate, input logic restart);
      estimate_req_type item;
      item.estimate = estimate;
      item.restart  = restart;
      estimates_pending.insert(estimates_pending.size(), item);
   endtask

   // Random tables. Most are well-formed: a restart followed by a run of
   // estimates, usually short, sometimes up to the full depth, and now and
   // then past it so the overflow error shows up. A few start without a
   // restart, which continues the previous table, and a few restart midway.
   task automatic queue_tables(input int count);
      int queued;
      int length;
      int shape;
      int flavor;
      int base;
      int est;
      logic restart;
      queued = 0;
      while (queued < count) begin
         shape = $urandom_range(99);
         if (shape < 70) length = $urandom_range(6, 1);
         else if (shape < 90) length = $urandom_range(16, 7);
         else length = $urandom_range(19, 17);
         base   = $urandom();
         flavor = $urandom_range(9);
         for (int i = 0; i < length; i++) begin
            if (flavor < 6) begin
               // Converging estimates, as a real integrand would give.
               est = base + (int'($urandom()) >>> (2 + 2 * i));
            end else if (flavor < 8) begin
               est = $urandom();
            end else begin
               case ($urandom_range(3))
                  0:       est = 32'h7FFF_FFFF;
                  1:       est = 32'h8000_0000;
                  2:       est = 32'h0000_0000;
                  default: est = 32'hFFFF_FFFF;
               endcase
            end
            if (i == 0) restart = ($urandom_range(9) != 0);
            else restart = ($urandom_range(19) == 0);
            offer(est, restart);
            queued++;
         end
      end
   endtask

   // Holds the sender back until every offered request is in and every
   // predicted entry has come out. Checked at the falling edge, away from
   // the edge where the handshakes and the predictor act.
   task automatic drain();
      while (estimates_pending.size() != 0 || req_bus.valid === 1'b1 ||
             entries_due.size() != 0)
         @(negedge clock);
   endtask

   // Request side. A new request is offered only when the channel is free or
   // the current one is being taken, so valid is assigned once per edge.
   // The predictor reads the payload as it stood before this edge.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            extend_diagonal(req_bus.estimate, req_bus.restart);
         if (!req_bus.valid || req_bus.ready) begin
            if (estimates_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = estimates_pending.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.estimate <= next_req.estimate;
               req_bus.restart  <= next_req.restart;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response side: checks each entry that is taken against the oldest
   // prediction, then decides ready for the next cycle. A long hold-off,
   // once asked for, is counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_entry.row    = rsp_bus.row;
            seen_entry.column = rsp_bus.column;
            seen_entry.value  = rsp_bus.value;
            seen_entry.last   = rsp_bus.last;
            seen_entry.error  = rsp_bus.error;
            if (entries_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("extra entry: row %0d column %0d value %0d last %0b error %0b",
                           seen_entry.row, seen_entry.column, seen_entry.value,
                           seen_entry.last, seen_entry.error);
            end else begin
               want_entry = entries_due.pop_front();
               if (seen_entry.row !== want_entry.row || seen_entry.column !== want_entry.column ||
                   seen_entry.value !== want_entry.value ||
                   seen_entry.last !== want_entry.last ||
                   seen_entry.error !== want_entry.error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("expected %0d %0d %0d %0b %0b, actual %0d %0d %0d %0b %0b",
                              want_entry.row, want_entry.column, want_entry.value,
                              want_entry.last, want_entry.error,
                              seen_entry.row, seen_entry.column, seen_entry.value,
                              seen_entry.last, seen_entry.error);
               end
            end
         end
         if (stalls_begun != stalls_asked) begin
            stall_left = LONG_STALL;
            stalls_begun++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: a run that stops moving on both channels is a hang.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("romberg_extrapolation_table: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.estimate = '0;
      req_bus.restart  = 1'b0;
      rsp_bus.ready    = 1'b0;
      for (int j = 0; j < STORE_DEPTH; j++) diagonal_copy[j] = '0;
      next_level = '0;

      // Directed part. The first estimate comes without a restart, which
      // must still open a table since the level count is zero after reset.
      offer(32'h7FFF_FFFF, 1'b0);
      // Fill the table to its full depth. Alternating extremes drive the
      // extrapolation into saturation on both sides; the later estimates
      // converge on one, as Q16.16.
      for (int i = 1; i <= LEVEL_LIMIT; i++) begin
         if (i < 8) offer((i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0);
         else offer(32'h0001_0000 + (32'h0000_1000 >> i), 1'b0);
      end
      // One past the limit, twice: each is dropped with an error entry and
      // the table stays as it was.
      offer(32'h1234_5678, 1'b0);
      offer(32'h0000_0000, 1'b0);
      offer(32'h0000_0000, 1'b1);
      offer(32'hFFFF_FFFF, 1'b0);
      offer(32'h8000_0000, 1'b0);
      // Restart while a table is open abandons it.
      offer(32'h0003_2440, 1'b1);
      offer(32'h0003_243F, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // First third: the sender idles a little, the receiver a lot.
      queue_tables(90);
      @(negedge clock);
      drain();

      // Second third: the other way round.
      send_idle_pct = 75;
      recv_idle_pct = 10;
      queue_tables(95);
      drain();

      // Last third: no idling, but it opens with a long receiver hold-off
      // while requests keep coming, so the block backs up into its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_tables(95);
      stalls_asked++;
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && entries_due.size() == 0) begin
         $display("romberg_extrapolation_table: match");
      end else begin
         $display("romberg_extrapolation_table: mismatch");
      end
      $finish;
   end

endmodule
